@@ rtl/lts_pkg.sv @@
package lts_pkg;

  // width of the saturating run counter
  localparam int LENGTH_BITS = 16;
  // width of the reported token length
  localparam int TOK_LEN_W   = 16;
  localparam int KIND_W      = 5;

  typedef logic [KIND_W-1:0]    tok_kind_t;
  typedef logic [TOK_LEN_W-1:0] tok_len_t;

  localparam tok_kind_t K_SPACE   = 5'd0;
  localparam tok_kind_t K_TAB     = 5'd1;
  localparam tok_kind_t K_LF      = 5'd2;
  localparam tok_kind_t K_CR      = 5'd3;
  localparam tok_kind_t K_CRLF    = 5'd4;
  localparam tok_kind_t K_LPAREN  = 5'd5;
  localparam tok_kind_t K_RPAREN  = 5'd6;
  localparam tok_kind_t K_LBRACK  = 5'd7;
  localparam tok_kind_t K_RBRACK  = 5'd8;
  localparam tok_kind_t K_LBRACE  = 5'd9;
  localparam tok_kind_t K_RBRACE  = 5'd10;
  localparam tok_kind_t K_SLASH   = 5'd11;
  localparam tok_kind_t K_INT     = 5'd12;
  localparam tok_kind_t K_DEC     = 5'd13;
  localparam tok_kind_t K_STR     = 5'd14;
  localparam tok_kind_t K_COMMENT = 5'd15;
  localparam tok_kind_t K_IDENT   = 5'd16;
  localparam tok_kind_t K_UNKNOWN = 5'd17;
  localparam tok_kind_t K_END     = 5'd18;

  typedef struct packed {
    tok_kind_t kind;
    tok_len_t  len;
    logic      last;
  } token_t;

  // tokens caused by one byte; v1 set implies v0 set
  typedef struct packed {
    logic   v0;
    token_t tok0;
    logic   v1;
    token_t tok1;
  } tok_pair_t;

endpackage

@@ rtl/lisp_token_scanner_top.sv @@
// channel | dir | tdata (low bit up)                        | tlast
// in_     | in  | [7:0] src_byte                            | -
// out_    | out | [4:0] token_kind, [20:5] token_length, 0s | last_of_run
//
// one source byte per cycle while out_tready holds and each byte closes at
// most one token; bytes that yield two tokens fill the four-entry token queue
// faster than the single output port drains it, and input then waits for room
// path: byte register, then scan logic into the token queue, which feeds out_
// synchronous active-low reset returns the scanner to start mode, length zero
// in_tready depends only on internal state, never on out_tready
module lisp_token_scanner_top
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // source bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] src_byte
  // tokens
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [4:0] token_kind, [20:5] token_length
  output logic        out_tlast    // last_of_run
);

  logic       byte_full_r;
  logic [7:0] byte_r;
  logic       fire;      // scan the held byte this cycle
  logic       has_room;
  tok_pair_t  pair;
  token_t     head;

  // the held byte is scanned once the queue has room for both tokens
  assign fire      = byte_full_r && has_room;
  assign in_tready = !byte_full_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_full_r <= 1'b0;
    end else if (in_tready) begin
      byte_full_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  lts_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .src_byte (byte_r),
    .pair     (pair)
  );

  lts_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pair),
    .pop       (out_tready),
    .has_room  (has_room),
    .not_empty (out_tvalid),
    .head      (head)
  );

  assign out_tdata = {3'b000, head.len, head.kind};
  assign out_tlast = head.last;

endmodule

@@ rtl/lts_scan.sv @@
module lts_scan
  import lts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] src_byte,
  output tok_pair_t  pair
);

  typedef enum logic [3:0] {
    M_START, M_SPACE, M_TAB, M_CR, M_IDENT, M_DEC, M_INT, M_STR,
    M_COMMENT, M_COMMENT_CR, M_UNI4, M_UNI3, M_UNI2
  } mode_t;

  typedef logic [LENGTH_BITS-1:0] run_t;

  localparam run_t RUN_CAP = {LENGTH_BITS{1'b1}};
  localparam run_t RUN_ONE = run_t'(1);

  mode_t mode_r, mode_nxt;
  run_t  run_r, run_nxt;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
           (b == 8'h00) || (b == 8'h3B) || (b == 8'h2F) || (b == 8'h28) ||
           (b == 8'h29) || (b == 8'h5B) || (b == 8'h5D) || (b == 8'h7B) ||
           (b == 8'h7D);
  endfunction

  function automatic tok_len_t sat_len(input run_t v);
    return (32'(v) > 32'h0000_FFFF) ? {TOK_LEN_W{1'b1}} : tok_len_t'(v);
  endfunction

  logic      byte_is_num;
  run_t      run_inc;

  // what the byte does as the first byte of a token
  logic      b_emit;
  tok_kind_t b_kind;
  tok_len_t  b_len;
  mode_t     b_mode;
  run_t      b_run;

  // what the byte does to the open token
  logic      c_emit;    // open token closes
  tok_kind_t c_kind;
  tok_len_t  c_len;
  logic      c_begin;   // byte then starts a new token

  assign byte_is_num = (src_byte >= 8'h30) && (src_byte <= 8'h39);
  assign run_inc  = (run_r == RUN_CAP) ? run_r : run_r + RUN_ONE;

  always_comb begin
    b_emit = 1'b1;
    b_kind = K_UNKNOWN;
    b_len  = tok_len_t'(1);
    b_mode = M_START;
    priority if (src_byte == 8'h00) begin
      b_kind = K_END;
      b_len  = '0;
    end else if (src_byte == 8'h09) begin
      b_emit = 1'b0;
      b_mode = M_TAB;
    end else if (src_byte == 8'h0A) begin
      b_kind = K_LF;
    end else if (src_byte == 8'h0D) begin
      b_emit = 1'b0;
      b_mode = M_CR;
    end else if (src_byte == 8'h20) begin
      b_emit = 1'b0;
      b_mode = M_SPACE;
    end else if (src_byte == 8'h22) begin
      b_emit = 1'b0;
      b_mode = M_STR;
    end else if (src_byte == 8'h3B) begin
      b_emit = 1'b0;
      b_mode = M_COMMENT;
    end else if (src_byte == 8'h28) begin
      b_kind = K_LPAREN;
    end else if (src_byte == 8'h29) begin
      b_kind = K_RPAREN;
    end else if (src_byte == 8'h5B) begin
      b_kind = K_LBRACK;
    end else if (src_byte == 8'h5D) begin
      b_kind = K_RBRACK;
    end else if (src_byte == 8'h7B) begin
      b_kind = K_LBRACE;
    end else if (src_byte == 8'h7D) begin
      b_kind = K_RBRACE;
    end else if (src_byte == 8'h2F) begin
      b_kind = K_SLASH;
    end else if (byte_is_num) begin
      b_emit = 1'b0;
      b_mode = M_INT;
    end else if ((src_byte >= 8'h21) && (src_byte <= 8'h7E)) begin
      b_emit = 1'b0;
      b_mode = M_IDENT;
    end else if ((src_byte >= 8'hC0) && (src_byte <= 8'hDF)) begin
      b_emit = 1'b0;
      b_mode = M_UNI2;
    end else if ((src_byte >= 8'hE0) && (src_byte <= 8'hEF)) begin
      b_emit = 1'b0;
      b_mode = M_UNI3;
    end else if ((src_byte >= 8'hF0) && (src_byte <= 8'hF7)) begin
      b_emit = 1'b0;
      b_mode = M_UNI4;
    end else begin
      b_kind = K_UNKNOWN;
    end
    b_run = b_emit ? '0 : RUN_ONE;
  end

  always_comb begin
    c_emit   = 1'b0;
    c_kind   = K_UNKNOWN;
    c_len    = sat_len(run_r);
    c_begin  = 1'b0;
    mode_nxt = mode_r;
    run_nxt  = run_inc;
    unique case (mode_r)
      M_SPACE: begin
        if (src_byte != 8'h20) begin
          c_emit = 1'b1; c_kind = K_SPACE; c_begin = 1'b1;
        end
      end
      M_TAB: begin
        if (src_byte != 8'h09) begin
          c_emit = 1'b1; c_kind = K_TAB; c_begin = 1'b1;
        end
      end
      M_CR: begin
        c_emit = 1'b1;
        if (src_byte == 8'h0A) begin
          c_kind = K_CRLF; c_len = sat_len(run_inc);
          mode_nxt = M_START; run_nxt = '0;
        end else begin
          c_kind = K_CR; c_begin = 1'b1;
        end
      end
      M_INT: begin
        if (src_byte == 8'h2E) begin
          mode_nxt = M_DEC;
        end else if (is_delim(src_byte)) begin
          c_emit = 1'b1; c_kind = K_INT; c_begin = 1'b1;
        end else if (!byte_is_num) begin
          mode_nxt = M_IDENT;
        end
      end
      M_DEC: begin
        if (is_delim(src_byte)) begin
          c_emit = 1'b1; c_kind = K_DEC; c_begin = 1'b1;
        end else if (!byte_is_num) begin
          mode_nxt = M_IDENT;
        end
      end
      M_STR: begin
        if (src_byte == 8'h22) begin
          c_emit = 1'b1; c_kind = K_STR; c_len = sat_len(run_inc);
          mode_nxt = M_START; run_nxt = '0;
        end
      end
      M_COMMENT: begin
        if (src_byte == 8'h0A) begin
          c_emit = 1'b1; c_kind = K_COMMENT; c_len = sat_len(run_inc);
          mode_nxt = M_START; run_nxt = '0;
        end else if (src_byte == 8'h0D) begin
          mode_nxt = M_COMMENT_CR;
        end
      end
      M_COMMENT_CR: begin
        c_emit = 1'b1; c_kind = K_COMMENT;
        if (src_byte == 8'h0A) begin
          c_len = sat_len(run_inc);
          mode_nxt = M_START; run_nxt = '0;
        end else begin
          c_begin = 1'b1;
        end
      end
      M_UNI4:  mode_nxt = M_UNI3;
      M_UNI3:  mode_nxt = M_UNI2;
      M_UNI2:  mode_nxt = M_IDENT;
      M_IDENT: begin
        if (is_delim(src_byte)) begin
          c_emit = 1'b1; c_kind = K_IDENT; c_begin = 1'b1;
        end
      end
      default: begin
        c_begin = 1'b1;
      end
    endcase
    if (c_begin) begin
      mode_nxt = b_mode;
      run_nxt  = b_run;
    end
  end

  // pack so the first token always sits in slot 0
  always_comb begin
    pair = '0;
    if (c_emit) begin
      pair.v0        = 1'b1;
      pair.tok0.kind = c_kind;
      pair.tok0.len  = c_len;
      pair.tok0.last = !(c_begin && b_emit);
      if (c_begin && b_emit) begin
        pair.v1        = 1'b1;
        pair.tok1.kind = b_kind;
        pair.tok1.len  = b_len;
        pair.tok1.last = 1'b1;
      end
    end else if (c_begin && b_emit) begin
      pair.v0        = 1'b1;
      pair.tok0.kind = b_kind;
      pair.tok0.len  = b_len;
      pair.tok0.last = 1'b1;
    end
    if (!fire) begin
      pair.v0 = 1'b0;
      pair.v1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      run_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule

@@ rtl/lts_tokq.sv @@
module lts_tokq
  import lts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tok_pair_t push,
  input  logic      pop,
  output logic      has_room,   // room for two more tokens
  output logic      not_empty,
  output token_t    head
);

  token_t      slot_r [4];
  logic [1:0]  wptr_r, rptr_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  wptr_nxt;
  logic [1:0]  push_n;
  logic        do_pop;

  assign not_empty = (cnt_r != 3'd0);
  assign has_room  = (cnt_r <= 3'd2);
  assign head      = slot_r[rptr_r];
  assign do_pop    = pop && not_empty;
  assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
  assign wptr_nxt  = wptr_r + 2'd1;
  assign cnt_nxt   = cnt_r + {1'b0, push_n} - {2'b0, do_pop};

  always_ff @(posedge clk) begin
    if (push.v0) begin
      slot_r[wptr_r] <= push.tok0;
    end
    if (push.v1) begin
      slot_r[wptr_nxt] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + push_n;
      if (do_pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ dv/tb_lisp_token_scanner_top.sv @@
`timescale 1ns / 1ps

package lts_tb_pkg;
  import lts_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] UTF2_LO   = 8'hC0;
  localparam logic [7:0] UTF2_HI   = 8'hDF;
  localparam logic [7:0] UTF3_LO   = 8'hE0;
  localparam logic [7:0] UTF3_HI   = 8'hEF;
  localparam logic [7:0] UTF4_LO   = 8'hF0;
  localparam logic [7:0] UTF4_HI   = 8'hF7;
  localparam logic [7:0] BAD_LO    = 8'hF8;
  localparam logic [7:0] BAD_HI    = 8'hFF;

  localparam longint unsigned TOK_LEN_MAX = (64'd1 << TOK_LEN_W) - 1;

  typedef logic [LENGTH_BITS-1:0] run_len_t;

  typedef enum logic [3:0] {
    SC_START, SC_SPACE, SC_TAB, SC_CR, SC_IDENT, SC_DEC, SC_INT, SC_STR,
    SC_COMMENT, SC_COMMENT_CR, SC_UTF_3LEFT, SC_UTF_2LEFT, SC_UTF_1LEFT
  } scan_mode_e;

  function automatic bit is_numeral(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic bit is_delim(logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL, CH_SEMI, CH_SLASH,
      CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE:
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  // mirrors the scanner: open token mode, saturating length, tokens owed
  class scanner_mirror;
    scan_mode_e mode;
    run_len_t   run_len;
    token_t     step_tokens[$];
    token_t     pending_tokens[$];
    int         mismatches;

    function new();
      mode       = SC_START;
      run_len    = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction

    function run_len_t sat_inc(run_len_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void emit(tok_kind_t kind, run_len_t len);
      token_t          t;
      longint unsigned l;
      l      = 64'(len);
      t.kind = kind;
      t.len  = (l > TOK_LEN_MAX) ? '1 : l[TOK_LEN_W-1:0];
      t.last = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void open_run(scan_mode_e m);
      mode    = m;
      run_len = 1;
    endfunction

    function void grow(scan_mode_e m);
      mode    = m;
      run_len = sat_inc(run_len);
    endfunction

    // the current byte belongs to the token being closed
    function void close_incl(tok_kind_t kind);
      emit(kind, sat_inc(run_len));
      mode    = SC_START;
      run_len = '0;
    endfunction

    function void start_token(logic [7:0] b);
      mode    = SC_START;
      run_len = '0;
      case (b)
        CH_NUL:    emit(K_END, 0);
        CH_TAB:    open_run(SC_TAB);
        CH_LF:     emit(K_LF, 1);
        CH_CR:     open_run(SC_CR);
        CH_SPACE:  open_run(SC_SPACE);
        CH_QUOTE:  open_run(SC_STR);
        CH_SEMI:   open_run(SC_COMMENT);
        CH_LPAREN: emit(K_LPAREN, 1);
        CH_RPAREN: emit(K_RPAREN, 1);
        CH_LBRACK: emit(K_LBRACK, 1);
        CH_RBRACK: emit(K_RBRACK, 1);
        CH_LBRACE: emit(K_LBRACE, 1);
        CH_RBRACE: emit(K_RBRACE, 1);
        CH_SLASH:  emit(K_SLASH, 1);
        default: begin
          if (is_numeral(b)) open_run(SC_INT);
          else if (b >= CH_BANG && b <= CH_TILDE) open_run(SC_IDENT);
          else if (b >= UTF2_LO && b <= UTF2_HI) open_run(SC_UTF_1LEFT);
          else if (b >= UTF3_LO && b <= UTF3_HI) open_run(SC_UTF_2LEFT);
          else if (b >= UTF4_LO && b <= UTF4_HI) open_run(SC_UTF_3LEFT);
          else emit(K_UNKNOWN, 1);
        end
      endcase
    endfunction

    function void close_and_start(tok_kind_t kind, logic [7:0] b);
      emit(kind, run_len);
      start_token(b);
    endfunction

    function void note_byte(logic [7:0] b);
      token_t t;
      step_tokens.delete();
      case (mode)
        SC_SPACE:
          if (b == CH_SPACE) grow(SC_SPACE);
          else close_and_start(K_SPACE, b);
        SC_TAB:
          if (b == CH_TAB) grow(SC_TAB);
          else close_and_start(K_TAB, b);
        SC_CR:
          if (b == CH_LF) close_incl(K_CRLF);
          else close_and_start(K_CR, b);
        SC_INT:
          if (b == CH_DOT) grow(SC_DEC);
          else if (is_delim(b)) close_and_start(K_INT, b);
          else if (!is_numeral(b)) grow(SC_IDENT);
          else grow(SC_INT);
        SC_DEC:
          if (is_delim(b)) close_and_start(K_DEC, b);
          else if (!is_numeral(b)) grow(SC_IDENT);
          else grow(SC_DEC);
        SC_STR:
          if (b == CH_QUOTE) close_incl(K_STR);
          else grow(SC_STR);
        SC_COMMENT:
          if (b == CH_LF) close_incl(K_COMMENT);
          else if (b == CH_CR) grow(SC_COMMENT_CR);
          else grow(SC_COMMENT);
        SC_COMMENT_CR:
          if (b == CH_LF) close_incl(K_COMMENT);
          else close_and_start(K_COMMENT, b);
        SC_UTF_3LEFT: grow(SC_UTF_2LEFT);
        SC_UTF_2LEFT: grow(SC_UTF_1LEFT);
        SC_UTF_1LEFT: grow(SC_IDENT);
        SC_IDENT:
          if (is_delim(b)) close_and_start(K_IDENT, b);
          else grow(SC_IDENT);
        default: start_token(b);
      endcase
      foreach (step_tokens[i]) begin
        t      = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        pending_tokens.push_back(t);
      end
    endfunction

    function void check_token(tok_kind_t kind, tok_len_t len, logic last);
      token_t exp_tok;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d length %0d last %0b", kind, len, last);
        mismatches++;
        return;
      end
      exp_tok = pending_tokens.pop_front();
      if (kind !== exp_tok.kind) begin
        $error("token_kind: expected %0d, actual %0d", exp_tok.kind, kind);
        mismatches++;
      end
      if (len !== exp_tok.len) begin
        $error("token_length: expected %0d, actual %0d", exp_tok.len, len);
        mismatches++;
      end
      if (last !== exp_tok.last) begin
        $error("last_of_run: expected %0b, actual %0b", exp_tok.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

module tb_lisp_token_scanner_top;
  import lts_pkg::*;
  import lts_tb_pkg::*;

  // random source words after the opening and long-run parts
  localparam int RANDOM_BYTES     = 1850;
  // one long space run, closed by a line feed
  localparam int LONG_RUN_BYTES   = 64;
  // sink holds off this long once, so the token queue backs up
  localparam int LONG_HOLD_CYCLES = 300;
  // watchdog: cycles with no word moving on either side
  localparam int STALL_LIMIT      = 2000;
  // settling cycles after the last owed token, before the verdict
  localparam int TAIL_CYCLES      = 8;

  // brackets and slash, each a one-byte token
  localparam logic [6:0][7:0] SINGLE_BYTE_TOKENS = {
    CH_SLASH, CH_RBRACE, CH_LBRACE, CH_RBRACK, CH_LBRACK, CH_RPAREN, CH_LPAREN
  };

  // token shapes that the random part strings together
  typedef enum int {
    FR_SPACES, FR_TABS, FR_LF, FR_CR, FR_CRLF, FR_SINGLE, FR_INT, FR_DEC,
    FR_INT_IDENT, FR_STRING, FR_COMMENT, FR_IDENT, FR_UTF8, FR_UNKNOWN,
    FR_NUL, FR_NOISE
  } fragment_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] src_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // [4:0] token_kind, [20:5] token_length, rest zero
  logic        out_tlast;    // last_of_run

  scanner_mirror mirror = new();

  // stimulus knobs shared with the sink process
  bit quiet         = 1'b0;  // no idling on either side near the end
  bit long_hold_req = 1'b0;  // sink holds off once for a long stretch
  int gap_odds      = 0;     // 0 means the source never pauses
  int bytes_sent    = 0;
  int idle_cycles;

  lisp_token_scanner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one source word, wait for the handshake, then maybe pause
  task automatic put_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.note_byte(b);
    bytes_sent++;
    // a pause always lets the clock tick with tvalid low, so tvalid never bounces
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // source goes quiet until every owed token has come out
  task automatic drain_tokens();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] ident_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_BANG, CH_TILDE)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] unknown_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: begin
        do c = 8'($urandom_range(1, 31));
        while (c == CH_TAB || c == CH_LF || c == CH_CR);
      end
      1: c = CH_DEL;
      2: c = 8'($urandom_range(CONT_LO, CONT_HI));
      default: c = 8'($urandom_range(BAD_LO, BAD_HI));
    endcase
    return c;
  endfunction

  // one well-formed token, or a bit of noise, with random content
  task automatic send_fragment();
    logic [7:0] c;
    int         n;
    fragment_e  shape;
    gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
    shape    = fragment_e'($urandom_range(FR_SPACES, FR_NOISE));
    case (shape)
      FR_SPACES: repeat ($urandom_range(1, 6)) put_byte(CH_SPACE);
      FR_TABS:   repeat ($urandom_range(1, 6)) put_byte(CH_TAB);
      FR_LF:     put_byte(CH_LF);
      FR_CR:     put_byte(CH_CR);
      FR_CRLF: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      FR_SINGLE: put_byte(SINGLE_BYTE_TOKENS[3'($urandom_range(0, 6))]);
      FR_INT:    repeat ($urandom_range(1, 5)) put_byte(digit_char());
      FR_DEC: begin
        repeat ($urandom_range(1, 3)) put_byte(digit_char());
        put_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) put_byte(digit_char());
        // a second period or an identifier byte that is no digit turns it into an identifier
        if ($urandom_range(0, 3) == 0) put_byte(CH_DOT);
        else if ($urandom_range(0, 3) == 0) put_byte(ident_char());
      end
      FR_INT_IDENT: begin
        repeat ($urandom_range(1, 3)) put_byte(digit_char());
        repeat ($urandom_range(1, 3)) put_byte(ident_char());
      end
      FR_STRING: begin
        put_byte(CH_QUOTE);
        n = $urandom_range(0, 8);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
          put_byte(c);
        end
        // now and then left open, so later words land inside it
        if ($urandom_range(0, 7) != 0) put_byte(CH_QUOTE);
      end
      FR_COMMENT: begin
        put_byte(CH_SEMI);
        repeat ($urandom_range(0, 8)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
          put_byte(c);
        end
        // lf, cr lf, or a bare cr that the next word closes
        case ($urandom_range(0, 2))
          0: put_byte(CH_LF);
          1: begin
            put_byte(CH_CR);
            put_byte(CH_LF);
          end
          default: put_byte(CH_CR);
        endcase
      end
      FR_IDENT: repeat ($urandom_range(1, 6)) put_byte(ident_char());
      FR_UTF8: begin
        n = $urandom_range(1, 3);
        case (n)
          1: put_byte(8'($urandom_range(UTF2_LO, UTF2_HI)));
          2: put_byte(8'($urandom_range(UTF3_LO, UTF3_HI)));
          default: put_byte(8'($urandom_range(UTF4_LO, UTF4_HI)));
        endcase
        // continuation words may hold any value, zero included
        repeat (n) put_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) put_byte(ident_char());
      end
      FR_UNKNOWN: put_byte(unknown_char());
      FR_NUL:     put_byte(CH_NUL);
      default:    repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // token sink: random holds, one long hold on request, always ready when quiet
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // token checks and the stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        mirror.check_token(out_tdata[4:0], out_tdata[20:5], out_tlast);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[lisp_token_scanner_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] opening_text[$];
    int         random_end;
    bit         hold_done;
    bit         drain_done;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= CH_NUL;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening: every single-byte token, int to decimal, runs, cr lf,
    // zero and 0xff inside a string, comment closed by a non-lf after cr,
    // zero ending an identifier, zero inside utf-8 continuation words,
    // scanning on after the end token, unknown words, cr then unknown
    opening_text = '{
      CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_SLASH,
      CH_0, CH_DOT, CH_9, CH_SPACE, CH_TAB, CH_CR, CH_LF,
      CH_QUOTE, CH_NUL, BAD_HI, CH_QUOTE,
      CH_SEMI, CH_CR, CH_TILDE, CH_NUL,
      UTF4_LO, CH_NUL, CONT_LO, CH_UPPER_A, CH_NUL,
      CH_DEL, CH_LF, CH_CR, BAD_LO
    };
    gap_odds = 4;
    foreach (opening_text[i]) put_byte(opening_text[i]);
    drain_tokens();

    // one long space run, closed by a line feed
    gap_odds = 16;
    repeat (LONG_RUN_BYTES) put_byte(CH_SPACE);
    put_byte(CH_LF);
    drain_tokens();

    random_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_end) begin
      // long sink hold while the source keeps offering words
      if (!hold_done && bytes_sent >= random_end - 1500) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      // source pauses until every owed token is out
      if (!drain_done && bytes_sent >= random_end - 800) begin
        drain_tokens();
        drain_done = 1'b1;
      end
      if (bytes_sent >= random_end - 250) quiet = 1'b1;
      send_fragment();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("[lisp_token_scanner_top] OK");
    end else begin
      $display("[lisp_token_scanner_top] ERROR");
    end
    $finish;
  end

endmodule
